### rtl/lss_pkg.sv
// ----------------------------------------------------------------------------
// lss_pkg
// command and status codes and the result record of the search stack
// ----------------------------------------------------------------------------
package lss_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned POS_W  = 4;
    localparam int unsigned OCC_W  = 5;

    typedef enum logic [1:0] {
        CMD_PUSH   = 2'd0,
        CMD_POP    = 2'd1,
        CMD_PEEK   = 2'd2,
        CMD_SEARCH = 2'd3
    } lss_cmd_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } lss_status_t;

    typedef struct packed {
        logic [OCC_W-1:0]  occupancy;
        logic              is_empty;
        lss_status_t       status;
        logic [POS_W-1:0]  position;
        logic              found;
        logic [DATA_W-1:0] result_value;
    } lss_res_t;

endpackage

### rtl/lss_ram.sv
// ----------------------------------------------------------------------------
// lss_ram
// entry store: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module lss_ram #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = 4
) (
    input  logic                      aclk,
    input  logic                      wr_en,
    input  logic [AW-1:0]             wr_addr,
    input  logic [lss_pkg::DATA_W-1:0] wr_data,
    input  logic                      rd_en,
    input  logic [AW-1:0]             rd_addr,
    output logic [lss_pkg::DATA_W-1:0] rd_data
);
    import lss_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/lss_ctrl.sv
// ----------------------------------------------------------------------------
// lss_ctrl
// command sequencer: stack pointer, memory accesses and the top-down scan
// ----------------------------------------------------------------------------
module lss_ctrl #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = 4,
    parameter int unsigned CW    = 5
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 in_cmd,
    input  logic [lss_pkg::DATA_W-1:0] in_operand,
    output logic                       res_valid,
    output lss_pkg::lss_res_t          res,
    input  logic                       out_free,
    output logic                       wr_en,
    output logic [AW-1:0]              wr_addr,
    output logic [lss_pkg::DATA_W-1:0] wr_data,
    output logic                       rd_en,
    output logic [AW-1:0]              rd_addr,
    input  logic [lss_pkg::DATA_W-1:0] rd_data
);
    import lss_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SCAN,
        S_HOLD
    } state_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [AW-1:0]     addr_reg, addr_next;
    logic [AW-1:0]     idx_reg, idx_next;
    logic [DATA_W-1:0] key_reg, key_next;
    lss_res_t          res_reg, res_next;
    logic              accept;
    logic [AW-1:0]     top_addr;
    logic [AW-1:0]     last_idx;

    assign in_ready  = aresetn &&
                       ((state_reg == S_IDLE) || ((state_reg == S_HOLD) && out_free));
    assign accept    = in_valid && in_ready;
    assign res_valid = (state_reg == S_HOLD);
    assign res       = res_reg;
    assign top_addr  = AW'(cnt_reg - CW'(1));
    assign last_idx  = top_addr;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        addr_next  = addr_reg;
        idx_next   = idx_reg;
        key_next   = key_reg;
        res_next   = res_reg;
        wr_en      = 1'b0;
        wr_addr    = AW'(cnt_reg);
        wr_data    = in_operand;
        rd_en      = 1'b0;
        rd_addr    = top_addr;

        case (state_reg)
            S_READ: begin
                res_next.result_value = rd_data;
                state_next            = S_HOLD;
            end
            S_SCAN: begin
                if (rd_data == key_reg) begin
                    res_next.found    = 1'b1;
                    res_next.position = POS_W'(idx_reg);
                    state_next        = S_HOLD;
                end else if (idx_reg == last_idx) begin
                    state_next = S_HOLD;
                end else begin
                    rd_en     = 1'b1;
                    rd_addr   = AW'(addr_reg - 1'b1);
                    addr_next = AW'(addr_reg - 1'b1);
                    idx_next  = AW'(idx_reg + 1'b1);
                end
            end
            S_HOLD: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
            end
        endcase

        if (accept) begin
            res_next   = '0;
            state_next = S_HOLD;
            case (lss_cmd_t'(in_cmd))
                CMD_PUSH: begin
                    if (cnt_reg == CW'(DEPTH)) begin
                        res_next.status = STAT_FULL;
                    end else begin
                        wr_en    = 1'b1;
                        cnt_next = CW'(cnt_reg + 1'b1);
                    end
                end
                CMD_POP: begin
                    if (cnt_reg == '0) begin
                        res_next.status = STAT_EMPTY;
                    end else begin
                        rd_en      = 1'b1;
                        cnt_next   = CW'(cnt_reg - 1'b1);
                        state_next = S_READ;
                    end
                end
                CMD_PEEK: begin
                    if (cnt_reg == '0) begin
                        res_next.status = STAT_EMPTY;
                    end else begin
                        rd_en      = 1'b1;
                        state_next = S_READ;
                    end
                end
                CMD_SEARCH: begin
                    if (cnt_reg == '0) begin
                        res_next.status = STAT_EMPTY;
                    end else begin
                        rd_en      = 1'b1;
                        addr_next  = top_addr;
                        idx_next   = '0;
                        key_next   = in_operand;
                        state_next = S_SCAN;
                    end
                end
                default: begin
                end
            endcase
            res_next.occupancy = OCC_W'(cnt_next);
            res_next.is_empty  = (cnt_next == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
        addr_reg <= addr_next;
        idx_reg  <= idx_next;
        key_reg  <= key_next;
        res_reg  <= res_next;
    end

endmodule

### rtl/lifo_stack_with_search.sv
// ----------------------------------------------------------------------------
// lifo_stack_with_search
// bounded stack of 32-bit words with push, pop, peek and search by value
// ----------------------------------------------------------------------------
// One command beat in, one result beat out. The entries sit in a single-port
// read, single-port write memory with registered read data, and that read
// port sets the order of work: a push writes the entry and answers without a
// read, a pop or peek reads the top entry and returns it, and a search reads
// one entry per cycle from the top down until the nearest match or the bottom
// entry. A pop, peek or search on an empty stack and a push on a full one are
// answered without a memory access. A result register on the output lets the
// next command be taken while a result waits.
// ----------------------------------------------------------------------------
module lifo_stack_with_search #(
    parameter int unsigned DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // operand_value
    input  logic [1:0]  s_tuser,   // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // result_value, found, position, status,
                                   // is_empty, occupancy, zero pad
);
    import lss_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic              res_valid;
    lss_res_t          res;
    logic              out_free;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [DATA_W-1:0] rd_data;
    logic              m_tvalid_reg, m_tvalid_next;
    lss_res_t          out_reg;

    lss_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_cmd     (s_tuser),
        .in_operand (s_tdata),
        .res_valid  (res_valid),
        .res        (res),
        .out_free   (out_free),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data)
    );

    lss_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // output register
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (res_valid && out_free) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
        if (res_valid && out_free) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, out_reg};

`ifndef SYNTHESIS
    a_found_ok : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_reg.found) |-> (out_reg.status == STAT_OK))
        else $error("match reported with a non-ok status");

    a_empty_flag : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_reg.status == STAT_EMPTY) |-> out_reg.is_empty)
        else $error("empty status on a non-empty stack");

    a_full_flag : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_reg.status == STAT_FULL) |-> !out_reg.is_empty)
        else $error("full status on an empty stack");

    a_res_hold : assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && !out_free) |=> res_valid)
        else $error("pending result dropped while output busy");
`endif

endmodule

### verif/lifo_stack_with_search_tb.sv
// ----------------------------------------------------------------------------
// lifo_stack_with_search_tb
// self-checking bench for the bounded search stack
// ----------------------------------------------------------------------------
// Drives push, pop, peek and search commands with random gaps and random
// result stalls, predicts each result from a local copy of the stack, and
// compares every result beat field by field in order. Directed commands hit
// the empty and full corners and the search cases, a long receiver hold-off
// fills the pipeline, and random traffic sweeps the stack up and down.
// ----------------------------------------------------------------------------
module lifo_stack_with_search_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lss_pkg::*;

    localparam int unsigned STACK_DEPTH = 16;
    localparam int unsigned RES_W       = $bits(lss_res_t);
    localparam int unsigned RANDOM_CMDS = 1750;

    localparam logic [31:0] FILL_WORDS [STACK_DEPTH] = '{
        32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0005,
        32'h0000_0000, 32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_0001,
        32'hFFFF_FFFE, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h7FFF_FFFE,
        32'h0000_0005, 32'h8000_0001, 32'h1357_9BDF, 32'h2468_ACE0
    };

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;

    logic [31:0] stack_words [STACK_DEPTH];
    int unsigned stack_fill = 0;
    lss_res_t    expected_results [$];

    int error_count = 0;
    int beat_count  = 0;
    int rx_wait     = 0;
    bit rx_hold     = 1'b0;
    bit no_idle     = 1'b0;

    lifo_stack_with_search #(
        .DEPTH(STACK_DEPTH)
    ) u_top (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),     // operand_value
        .s_tuser(s_tuser),     // cmd
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)      // result_value, found, position, status,
                               // is_empty, occupancy, zero pad
    );

    always #5 aclk = ~aclk;

    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic lss_res_t predict_stack_result(input lss_cmd_t cmd,
                                                      input logic [31:0] operand);
        lss_res_t r;
        int unsigned i;
        r = '0;
        r.status = STAT_OK;
        case (cmd)
            CMD_PUSH: begin
                if (stack_fill >= STACK_DEPTH) begin
                    r.status = STAT_FULL;
                end else begin
                    stack_words[stack_fill] = operand;
                    stack_fill++;
                end
            end
            CMD_POP: begin
                if (stack_fill == 0) begin
                    r.status = STAT_EMPTY;
                end else begin
                    stack_fill--;
                    r.result_value = stack_words[stack_fill];
                end
            end
            CMD_PEEK: begin
                if (stack_fill == 0)
                    r.status = STAT_EMPTY;
                else
                    r.result_value = stack_words[stack_fill - 1];
            end
            default: begin
                if (stack_fill == 0) begin
                    r.status = STAT_EMPTY;
                end else begin
                    for (i = 0; i < stack_fill; i++) begin
                        if (!r.found && stack_words[stack_fill - 1 - i] == operand) begin
                            r.found    = 1'b1;
                            r.position = i[POS_W-1:0];
                        end
                    end
                end
            end
        endcase
        r.is_empty  = (stack_fill == 0);
        r.occupancy = stack_fill[OCC_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t beat %0d %s: got %0h expected %0h", $time, beat_count, what,
                 got, want);
        error_count++;
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    // keep valid up across back-to-back beats, drop it only for a gap
    task automatic send_cmd(input lss_cmd_t cmd, input logic [31:0] operand);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= operand;
        s_tuser  <= cmd;
        do @(posedge aclk); while (!s_tready);
        expected_results.push_back(predict_stack_result(cmd, operand));
    endtask

    function automatic logic [31:0] pick_operand();
        logic [31:0] v;
        case ($urandom_range(0, 7))
            0: begin
                case ($urandom_range(0, 3))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7FFF_FFFF;
                    2: v = 32'hFFFF_FFFF;
                    default: v = 32'h0000_0000;
                endcase
            end
            1, 2: v = 32'($signed($urandom_range(0, 5)) - 2);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // result side: per-beat stall, plus a long hold-off when asked
    always @(posedge aclk) begin
        if (m_tvalid && m_tready)
            rx_wait = no_idle ? 0 : $urandom_range(0, 9);
        else if (rx_wait > 0)
            rx_wait = rx_wait - 1;
        m_tready <= !rx_hold && (rx_wait == 0);
    end

    always @(posedge aclk) begin
        lss_res_t got;
        lss_res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[RES_W-1:0];
            beat_count++;
            if (expected_results.size() == 0) begin
                report_mismatch("beat with nothing pending", m_tdata[31:0], '0);
            end else begin
                want = expected_results.pop_front();
                check_field("result_value", got.result_value, want.result_value);
                check_field("found", 32'(got.found), 32'(want.found));
                check_field("position", 32'(got.position), 32'(want.position));
                check_field("status", 32'(got.status), 32'(want.status));
                check_field("is_empty", 32'(got.is_empty), 32'(want.is_empty));
                check_field("occupancy", 32'(got.occupancy), 32'(want.occupancy));
                check_field("pad", 32'(m_tdata[47:RES_W]), '0);
            end
        end
    end

    task automatic test_empty_stack();
        send_cmd(CMD_POP, 32'hFFFF_FFFF);
        send_cmd(CMD_PEEK, 32'h0000_0000);
        send_cmd(CMD_SEARCH, 32'h0000_0000);
    endtask

    task automatic test_fill_and_search();
        foreach (FILL_WORDS[i])
            send_cmd(CMD_PUSH, FILL_WORDS[i]);
        send_cmd(CMD_PUSH, 32'h0000_0001);
        send_cmd(CMD_SEARCH, 32'h8000_0000);
        send_cmd(CMD_SEARCH, 32'h0000_0005);
        send_cmd(CMD_SEARCH, 32'h1234_5678);
        send_cmd(CMD_PEEK, 32'h0000_0000);
        send_cmd(CMD_POP, 32'h0000_0000);
    endtask

    task automatic test_output_backpressure();
        no_idle = 1'b1;
        fork
            begin
                rx_hold <= 1'b1;
                repeat (250) @(posedge aclk);
                rx_hold <= 1'b0;
            end
            begin
                repeat (40) begin
                    if ($urandom_range(0, 3) == 0)
                        send_cmd(CMD_POP, $urandom);
                    else
                        send_cmd(CMD_SEARCH, pick_operand());
                end
            end
        join
        no_idle = 1'b0;
    endtask

    task automatic test_random_traffic();
        bit          rising;
        int unsigned r;
        lss_cmd_t    cmd;
        logic [31:0] operand;
        rising = 1'b1;
        for (int n = 0; n < RANDOM_CMDS; n++) begin
            if (n % 150 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            if ((rising && stack_fill == STACK_DEPTH && $urandom_range(0, 3) == 0) ||
                (!rising && stack_fill == 0 && $urandom_range(0, 3) == 0) ||
                $urandom_range(0, 49) == 0)
                rising = !rising;
            r = $urandom_range(0, 99);
            if (rising)
                cmd = (r < 55) ? CMD_PUSH : (r < 70) ? CMD_POP :
                      (r < 80) ? CMD_PEEK : CMD_SEARCH;
            else
                cmd = (r < 15) ? CMD_PUSH : (r < 65) ? CMD_POP :
                      (r < 75) ? CMD_PEEK : CMD_SEARCH;
            if (cmd == CMD_SEARCH && stack_fill > 0 && $urandom_range(0, 9) < 7)
                operand = stack_words[$urandom_range(0, stack_fill - 1)];
            else
                operand = pick_operand();
            send_cmd(cmd, operand);
        end
        no_idle = 1'b0;
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_empty_stack();
        test_fill_and_search();
        test_output_backpressure();
        test_random_traffic();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
